@@ rtl/calibration_table_interpolator_macros.svh @@
// assertion macros for the calibration table interpolator
// expects clk_i and rst_ni in the scope of the including module
`ifndef CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define CTI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cti assertion failed");

// next-cycle implication, disabled during reset
`define CTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cti assertion failed");

`endif

@@ rtl/cti_pkg.sv @@
// types, constants and calibration tables of the calibration table interpolator
// no dependencies
package cti_pkg;

  localparam int IN_W       = 18;
  localparam int VAL_W      = 17;
  localparam int TABLE_LEN  = 15;
  localparam int SEG_W      = $clog2(TABLE_LEN);
  localparam int PROD_W     = 2 * VAL_W;
  localparam int CNT_W      = $clog2(PROD_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;
  localparam logic [VAL_W-1:0] MAX_OUT = 17'd95760;

  // opening in micrometres at each breakpoint
  localparam logic [VAL_W-1:0] OPEN_UM [TABLE_LEN] = '{
    17'd0,     17'd2100,  17'd4900,  17'd12280, 17'd18600,
    17'd23370, 17'd40900, 17'd53650, 17'd63080, 17'd71030,
    17'd78950, 17'd83850, 17'd88990, 17'd93300, 17'd95760
  };

  // actuator stroke at each breakpoint
  localparam logic [VAL_W-1:0] STROKE_PT [TABLE_LEN] = '{
    17'd0,   17'd20,  17'd40,  17'd60,  17'd80,
    17'd100, 17'd200, 17'd300, 17'd400, 17'd500,
    17'd600, 17'd700, 17'd800, 17'd900, 17'd1000
  };

  typedef enum logic {
    FUNC_OPEN_TO_STROKE = 1'b0,
    FUNC_STROKE_TO_OPEN = 1'b1
  } func_e;

  typedef enum logic {
    KIND_SAT = 1'b0,
    KIND_SEG = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  // classified work item passed from front to back
  typedef struct packed {
    func_e             func;
    kind_e             kind;
    logic [VAL_W-1:0]  y0;
    logic [VAL_W-1:0]  dx;
    logic [VAL_W-1:0]  dy;
    logic [VAL_W-1:0]  den;
  } desc_t;

endpackage

@@ rtl/cti_front.sv @@
// front end: range check and segment search against the calibration table
// depends on cti_pkg
module cti_front #(
  parameter int NUM_POINTS = 15
) (
  input  cti_pkg::func_e                     func_i,
  input  logic signed [cti_pkg::IN_W-1:0]    value_i,
  output cti_pkg::desc_t                     desc_o
);

  localparam int NPTS = (NUM_POINTS > cti_pkg::TABLE_LEN) ? cti_pkg::TABLE_LEN :
                        (NUM_POINTS < 2) ? 2 : NUM_POINTS;

  logic [cti_pkg::VAL_W-1:0] xs [cti_pkg::TABLE_LEN];
  logic [cti_pkg::VAL_W-1:0] ys [cti_pkg::TABLE_LEN];
  logic [cti_pkg::SEG_W-1:0] seg;
  logic [cti_pkg::SEG_W-1:0] seg_nx;
  logic [cti_pkg::IN_W-1:0]  dx_full;

  always_comb begin
    for (int k = 0; k < cti_pkg::TABLE_LEN; k++) begin
      if (func_i == cti_pkg::FUNC_STROKE_TO_OPEN) begin
        xs[k] = cti_pkg::STROKE_PT[k];
        ys[k] = cti_pkg::OPEN_UM[k];
      end else begin
        xs[k] = cti_pkg::OPEN_UM[k];
        ys[k] = cti_pkg::STROKE_PT[k];
      end
    end
  end

  // segment index is the count of inner breakpoints below the value
  always_comb begin
    seg = '0;
    for (int k = 1; k < NPTS - 1; k++) begin
      if (value_i > $signed({1'b0, xs[k]})) begin
        seg = seg + 1'b1;
      end
    end
  end

  assign seg_nx  = seg + 1'b1;
  assign dx_full = value_i - $signed({1'b0, xs[seg]});

  always_comb begin
    desc_o.func = func_i;
    desc_o.dx   = '0;
    desc_o.dy   = '0;
    desc_o.den  = '0;
    priority if (value_i <= $signed({1'b0, xs[0]})) begin
      desc_o.kind = cti_pkg::KIND_SAT;
      desc_o.y0   = ys[0];
    end else if (value_i >= $signed({1'b0, xs[NPTS-1]})) begin
      desc_o.kind = cti_pkg::KIND_SAT;
      desc_o.y0   = ys[NPTS-1];
    end else begin
      desc_o.kind = cti_pkg::KIND_SEG;
      desc_o.y0   = ys[seg];
      desc_o.dx   = dx_full[cti_pkg::VAL_W-1:0];
      desc_o.dy   = ys[seg_nx] - ys[seg];
      desc_o.den  = xs[seg_nx] - xs[seg];
    end
  end

endmodule

@@ rtl/cti_queue.sv @@
// short queue of classified items between front and back
// depends on cti_pkg
module cti_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cti_pkg::desc_t  desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cti_pkg::desc_t  desc_o
);

  localparam int PTR_W = $clog2(cti_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(cti_pkg::QUEUE_DEPTH + 1);

  cti_pkg::desc_t   mem_q [cti_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(cti_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign desc_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(cti_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(cti_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= desc_i;
    end
  end

endmodule

@@ rtl/cti_back.sv @@
// back end: multiply, bit-serial restoring divide and output register
// depends on cti_pkg and calibration_table_interpolator_macros.svh
`include "calibration_table_interpolator_macros.svh"

module cti_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  cti_pkg::desc_t             desc_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cti_pkg::func_e             out_func_o,
  output logic [cti_pkg::VAL_W-1:0]  out_value_o
);

  localparam int VAL_W  = cti_pkg::VAL_W;
  localparam int PROD_W = cti_pkg::PROD_W;
  localparam int CNT_W  = cti_pkg::CNT_W;

  cti_pkg::state_e   state_q, state_d;
  cti_pkg::desc_t    desc_q, desc_d;
  logic [PROD_W-1:0] pq_q, pq_d;
  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  cti_pkg::func_e    out_func_q, out_func_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    rem_sub;

  assign rem_sh  = {rem_q, pq_q[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, desc_q.den};

  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    pq_d        = pq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_func_d  = out_func_q;
    out_value_d = out_value_q;
    pop_o       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cti_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          desc_d = desc_i;
          if (desc_i.kind == cti_pkg::KIND_SAT) begin
            pq_d    = '0;
            state_d = cti_pkg::ST_DONE;
          end else begin
            state_d = cti_pkg::ST_MUL;
          end
        end
      end
      cti_pkg::ST_MUL: begin
        pq_d    = PROD_W'(desc_q.dx) * PROD_W'(desc_q.dy);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = cti_pkg::ST_DIV;
      end
      cti_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, desc_q.den}) begin
          rem_d = rem_sub[VAL_W-1:0];
          pq_d  = {pq_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[VAL_W-1:0];
          pq_d  = {pq_q[PROD_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = cti_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cti_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_func_d  = desc_q.func;
          out_value_d = desc_q.y0 + pq_q[VAL_W-1:0];
          state_d     = cti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cti_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q      <= desc_d;
    pq_q        <= pq_d;
    rem_q       <= rem_d;
    out_func_q  <= out_func_d;
    out_value_q <= out_value_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_func_o  = out_func_q;
  assign out_value_o = out_value_q;

  `CTI_ASSERT_IMPL(a_rem_below_den, state_q == cti_pkg::ST_DIV, rem_q < desc_q.den)
  `CTI_ASSERT_IMPL(a_cnt_in_range, state_q == cti_pkg::ST_DIV, cnt_q < CNT_W'(PROD_W))
  `CTI_ASSERT_IMPL(a_quot_fits, state_q == cti_pkg::ST_DONE, pq_q[PROD_W-1:VAL_W] == '0)
  `CTI_ASSERT_NEXT(a_sat_skips_div, state_q == cti_pkg::ST_IDLE && pop_o && desc_i.kind == cti_pkg::KIND_SAT, state_q == cti_pkg::ST_DONE && pq_q == '0)
  `CTI_ASSERT_IMPL(a_out_in_range, out_valid_q, out_value_q <= cti_pkg::MAX_OUT)

endmodule

@@ rtl/calibration_table_interpolator.sv @@
// Converts gripper finger opening (micrometres) to actuator stroke (0..1000) or back, through
// a 15-point calibration table with saturation at both ends and truncating linear interpolation.
// An item inside the table is picked up from the queue, multiplied, passed through 34 steps of the
// one-bit restoring divider and then loaded into the output register, which waits while a previous
// result is still held on the output. An item at or beyond either end skips the multiply and the
// divide: it is picked up from the queue and then loaded into the output register.
// The back end works on one item at a time and takes no new item until the last one is in the
// output register. A two-entry queue lets new items be accepted while the divider works and while
// a finished result waits on the output.
// depends on cti_pkg, cti_front, cti_queue, cti_back
module calibration_table_interpolator #(
  parameter int NUM_POINTS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cti_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [17:0] in_value, signed
  input  logic                                s_axis_tuser,   // [0] func
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cti_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [16:0] out_value
  output logic                                m_axis_tuser    // [0] out_func
);

  cti_pkg::desc_t            front_desc;
  cti_pkg::desc_t            queue_desc;
  logic                      queue_full;
  logic                      queue_empty;
  logic                      push;
  logic                      pop;
  cti_pkg::func_e            out_func;
  logic [cti_pkg::VAL_W-1:0] out_value;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  cti_front #(
    .NUM_POINTS(NUM_POINTS)
  ) u_front (
    .func_i  (cti_pkg::func_e'(s_axis_tuser)),
    .value_i ($signed(s_axis_tdata[cti_pkg::IN_W-1:0])),
    .desc_o  (front_desc)
  );

  cti_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (front_desc),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .desc_o  (queue_desc)
  );

  cti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .desc_i      (queue_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_func_o  (out_func),
    .out_value_o (out_value)
  );

  assign m_axis_tuser = out_func;
  assign m_axis_tdata = {{(cti_pkg::OUT_TDATA_W - cti_pkg::VAL_W){1'b0}}, out_value};

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the calibration table interpolator: directed and random
// conversions in both directions, checked against an in-bench interpolation predictor
// depends on cti_pkg and calibration_table_interpolator
module tb_top;
  import cti_pkg::*;

  localparam int NUM_POINTS     = 15;
  localparam int N_RANDOM       = 900;
  localparam int HOLD_AT_RESULT = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    func_e       func;
    logic [17:0] value;
    int          gap;
  } conv_req_t;

  typedef struct {
    func_e            func;
    logic [VAL_W-1:0] value;
  } conv_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [17:0] in_value, signed
  logic                   s_axis_tuser = 1'b0; // [0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [16:0] out_value
  logic                   m_axis_tuser;        // [0] out_func

  conv_req_t    cmd_queue[$];
  conv_result_t conv_expect_q[$];
  conv_req_t    next_req;
  conv_result_t exp_res;
  int           gap_left = 0;
  int           stall_left = 0;
  int           stall_next;
  int           result_cnt = 0;
  int           error_cnt = 0;
  int           idle_cycles = 0;
  bit           hold_done = 1'b0;

  calibration_table_interpolator #(
    .NUM_POINTS(NUM_POINTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // breakpoint i of the opening axis (um) or the stroke axis
  function automatic longint breakpoint_at(bit opening_axis, int i);
    longint op;
    longint sk;
    case (i)
      0:       begin op = 0;     sk = 0;    end
      1:       begin op = 2100;  sk = 20;   end
      2:       begin op = 4900;  sk = 40;   end
      3:       begin op = 12280; sk = 60;   end
      4:       begin op = 18600; sk = 80;   end
      5:       begin op = 23370; sk = 100;  end
      6:       begin op = 40900; sk = 200;  end
      7:       begin op = 53650; sk = 300;  end
      8:       begin op = 63080; sk = 400;  end
      9:       begin op = 71030; sk = 500;  end
      10:      begin op = 78950; sk = 600;  end
      11:      begin op = 83850; sk = 700;  end
      12:      begin op = 88990; sk = 800;  end
      13:      begin op = 93300; sk = 900;  end
      default: begin op = 95760; sk = 1000; end
    endcase
    return opening_axis ? op : sk;
  endfunction

  function automatic conv_result_t calib_convert(func_e f, logic signed [17:0] v);
    conv_result_t res;
    bit           x_open;
    int           n;
    longint       xv;
    longint       x0;
    longint       x1;
    longint       y0;
    longint       y1;
    longint       r;
    bit           found;
    x_open = (f == FUNC_OPEN_TO_STROKE);
    n = NUM_POINTS;
    if (n > 15) n = 15;
    if (n < 2) n = 2;
    xv = longint'(v);
    r = 0;
    found = 1'b0;
    if (xv <= breakpoint_at(x_open, 0)) begin
      r = breakpoint_at(!x_open, 0);
    end else if (xv >= breakpoint_at(x_open, n - 1)) begin
      r = breakpoint_at(!x_open, n - 1);
    end else begin
      for (int i = 0; i < n - 1; i++) begin
        x0 = breakpoint_at(x_open, i);
        x1 = breakpoint_at(x_open, i + 1);
        if (!found && xv >= x0 && xv <= x1) begin
          found = 1'b1;
          y0 = breakpoint_at(!x_open, i);
          y1 = breakpoint_at(!x_open, i + 1);
          r = (x1 <= x0) ? y0 : y0 + ((xv - x0) * (y1 - y0)) / (x1 - x0);
        end
      end
    end
    if (r < 0) r = 0;
    res.func  = f;
    res.value = r[VAL_W-1:0];
    return res;
  endfunction

  task automatic add_item(func_e f, int v, int gap);
    conv_req_t req;
    req.func  = f;
    req.value = v[17:0];
    req.gap   = gap;
    cmd_queue.push_back(req);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        conv_expect_q.push_back(calib_convert(func_e'(s_axis_tuser), s_axis_tdata[IN_W-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (cmd_queue.size() > 0) begin
          next_req      = cmd_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, next_req.value};
          s_axis_tuser  <= next_req.func;
          gap_left      <= next_req.gap;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      stall_next = stall_left;
      if (m_axis_tvalid && m_axis_tready) begin
        if (conv_expect_q.size() == 0) begin
          $display("%0t unexpected result: actual func %0d value %0d", $time,
                   m_axis_tuser, m_axis_tdata);
          error_cnt++;
        end else begin
          exp_res = conv_expect_q.pop_front();
          if (m_axis_tuser !== exp_res.func) begin
            $display("%0t out_func mismatch: expected %0d actual %0d", $time,
                     exp_res.func, m_axis_tuser);
            error_cnt++;
          end
          if (m_axis_tdata !== {{(OUT_TDATA_W - VAL_W){1'b0}}, exp_res.value}) begin
            $display("%0t out_value mismatch: expected %0d actual %0d", $time,
                     exp_res.value, m_axis_tdata);
            error_cnt++;
          end
        end
        result_cnt++;
        if (result_cnt % 200 < 40) stall_next = 0;
        else stall_next = $urandom_range(0, 11);
        if (result_cnt == HOLD_AT_RESULT && !hold_done) begin
          hold_done  = 1'b1;
          stall_next = HOLD_CYCLES;
        end
      end
      if (stall_next > 0) begin
        m_axis_tready <= 1'b0;
        stall_next--;
      end else begin
        m_axis_tready <= 1'b1;
      end
      stall_left <= stall_next;
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int     sel;
    int     v;
    int     gap;
    func_e  f;
    bit     x_open;

    // directed: extremes, both ends, breakpoints and interior points
    add_item(FUNC_OPEN_TO_STROKE, -131072, 0);
    add_item(FUNC_OPEN_TO_STROKE, -1, 0);
    add_item(FUNC_OPEN_TO_STROKE, 0, 0);
    add_item(FUNC_OPEN_TO_STROKE, 1, 0);
    add_item(FUNC_OPEN_TO_STROKE, 2099, 0);
    add_item(FUNC_OPEN_TO_STROKE, 2100, 0);
    add_item(FUNC_OPEN_TO_STROKE, 30000, 3);
    add_item(FUNC_OPEN_TO_STROKE, 95759, 0);
    add_item(FUNC_OPEN_TO_STROKE, 95760, 0);
    add_item(FUNC_OPEN_TO_STROKE, 95761, 0);
    add_item(FUNC_OPEN_TO_STROKE, 131071, 5);
    add_item(FUNC_STROKE_TO_OPEN, -131072, 0);
    add_item(FUNC_STROKE_TO_OPEN, -1, 0);
    add_item(FUNC_STROKE_TO_OPEN, 0, 0);
    add_item(FUNC_STROKE_TO_OPEN, 1, 0);
    add_item(FUNC_STROKE_TO_OPEN, 19, 0);
    add_item(FUNC_STROKE_TO_OPEN, 20, 2);
    add_item(FUNC_STROKE_TO_OPEN, 450, 0);
    add_item(FUNC_STROKE_TO_OPEN, 999, 0);
    add_item(FUNC_STROKE_TO_OPEN, 1000, 0);
    add_item(FUNC_STROKE_TO_OPEN, 1001, 0);
    add_item(FUNC_STROKE_TO_OPEN, 131071, 0);
    add_item(FUNC_STROKE_TO_OPEN, 96000, 1);

    // random: mostly in-table values, some near breakpoints, rest full range
    for (int k = 0; k < N_RANDOM; k++) begin
      gap = ((k / 50) % 4 == 0) ? 0 : $urandom_range(0, 11);
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        f = FUNC_OPEN_TO_STROKE;
        v = $urandom_range(0, 95760);
      end else if (sel < 55) begin
        f = FUNC_STROKE_TO_OPEN;
        v = $urandom_range(0, 1000);
      end else if (sel < 70) begin
        f = func_e'($urandom_range(0, 1));
        x_open = (f == FUNC_OPEN_TO_STROKE);
        v = int'(breakpoint_at(x_open, $urandom_range(0, 14))) + $urandom_range(0, 4) - 2;
      end else begin
        f = func_e'($urandom_range(0, 1));
        v = $urandom() & 32'h3FFFF;
      end
      add_item(f, v, gap);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (conv_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
